### rtl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; every other file imports this package.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // One beat from the front part to the compression engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_cmd_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: queue front part and compression back part.
// Depends on sha_pkg, sha_front and sha_back.
//
//   channel | direction | payload    | handshake
//   in_     | input     | sha_in_t   | in_valid / in_stall
//   out_    | output    | sha_out_t  | out_valid / out_stall
//
// A byte beat is gathered into the block; every 64th byte starts the rounds of that
// block, and no byte is gathered while they run.
// A last beat pads its block to 64 bytes at one byte a cycle and runs it; when fewer
// than nine bytes remain for the length, a second padding block and a second round
// pass follow. Eight output beats then go out. Reset restores the initial hash.
// Until full, the four-entry queue takes beats while rounds run or output stalls.
module sha256_stream_hasher #(
  parameter int unsigned QDEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  logic     q_valid, q_take;
  sha_cmd_t q_data;

  sha_front #(.DEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .q_valid, .q_take, .q_data
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data, .out_valid, .out_stall, .out_data
  );

endmodule

### rtl/sha_front.sv
// Front part: accepts input beats, drops idle beats and queues the rest.
// Depends on sha_pkg.
module sha_front #(
  parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              q_valid,
  input  logic              q_take,
  output sha_pkg::sha_cmd_t q_data
);
  import sha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_cmd_t          mem_r [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              acc, push, pop;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign acc      = in_valid && !in_stall;
  // A beat with neither a byte nor the last flag has no effect at all.
  assign push     = acc && (in_data.has_byte || in_data.last);
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_take;
  assign q_data   = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wp_nxt  = push ? inc(wp_r) : wp_r;
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data_byte: in_data.data_byte, has_byte: in_data.has_byte,
                       last: in_data.last};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !push) else $error("push while full");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop while empty");

endmodule

### rtl/sha_back.sv
// Back part: gathers bytes, pads, runs 64 rounds per block and emits digest.
// Depends on sha_pkg.
module sha_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  sha_pkg::sha_cmd_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::sha_out_t  out_data
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_GATHER = 5'b00001,
    S_PAD    = 5'b00010,
    S_LEN    = 5'b00100,
    S_ROUND  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   cv_r [8];
  logic [31:0]   w_r [16];
  logic [31:0]   v_r [8];
  logic [5:0]    fill_r;
  logic [63:0]   bits_r;
  logic [5:0]    rnd_r;
  logic [2:0]    oidx_r;
  logic          fin_r;    // the 0x80 marker has gone into the message
  logic          two_r;    // a further padding block follows this one
  logic [31:0]   w_new, w_cur, t1, t2;
  logic [7:0]    pad_byte;
  logic          take;

  assign q_take = (state_r == S_GATHER);
  assign take   = q_valid && q_take;

  always_comb begin
    w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
    w_cur = (rnd_r < 6'd16) ? w_r[0] : w_new;
    t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + ROUND_K[rnd_r] + w_cur;
    t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Padding fill: first byte after the message is 0x80, then zeros; the last
  // eight bytes of the final block carry the bit count.
  always_comb begin
    if (fill_r >= 6'd56 && !two_r) pad_byte = bits_r[8*(63-fill_r) +: 8];
    else if (fin_r) pad_byte = 8'h00;
    else pad_byte = PAD_BYTE;
  end

  logic [31:0] w_shift [16];
  logic [7:0]  byte_in;
  always_comb begin
    byte_in = (state_r == S_GATHER) ? q_data.data_byte : pad_byte;
    for (int i = 0; i < 15; i++) w_shift[i] = {w_r[i][23:0], w_r[i+1][31:24]};
    w_shift[15] = {w_r[15][23:0], byte_in};
  end

  assign out_valid = (state_r == S_EMIT);
  assign out_data  = '{digest_word: cv_r[oidx_r], word_index: oidx_r,
                       last_word: (oidx_r == 3'd7)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_GATHER: if (take) begin
        if (q_data.has_byte && fill_r == 6'd63) state_nxt = S_ROUND;
        else if (q_data.last) state_nxt = S_PAD;
      end
      S_PAD, S_LEN: if (fill_r == 6'd63) state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 6'd63) begin
        if (fin_r) state_nxt = two_r ? S_LEN : S_EMIT;
        else if (two_r) state_nxt = S_PAD;
        else state_nxt = S_GATHER;
      end
      S_EMIT: if (!out_stall && oidx_r == 3'd7) state_nxt = S_GATHER;
      default: state_nxt = S_GATHER;
    endcase
  end

  // fin_r is set once the 0x80 marker has gone into the block, so it stays low
  // through gathering and through the full block that a last byte may close.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_GATHER;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= INIT_HASH[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_GATHER: if (take) begin
          if (q_data.has_byte) begin
            fill_r <= fill_r + 6'd1;
            bits_r <= bits_r + 64'd8;
          end
          if (q_data.last) begin
            // After this beat the fill is fill_r + has_byte.
            two_r <= ({1'b0, fill_r} + {6'd0, q_data.has_byte}) >= 7'd56;
          end
          if (q_data.has_byte && fill_r == 6'd63) begin
            rnd_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
          end
        end
        S_PAD, S_LEN: begin
          fill_r <= fill_r + 6'd1;
          fin_r  <= 1'b1;
          if (fill_r == 6'd63) begin
            rnd_r <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
          end
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          for (int i = 1; i < 4; i++) v_r[i] <= v_r[i-1];
          for (int i = 5; i < 8; i++) v_r[i] <= v_r[i-1];
          v_r[0] <= t1 + t2;
          v_r[4] <= v_r[3] + t1;
          if (rnd_r == 6'd63) begin
            cv_r[0] <= cv_r[0] + t1 + t2;
            cv_r[4] <= cv_r[4] + v_r[3] + t1;
            for (int i = 1; i < 4; i++) cv_r[i] <= cv_r[i] + v_r[i-1];
            for (int i = 5; i < 8; i++) cv_r[i] <= cv_r[i] + v_r[i-1];
            if (two_r) two_r <= 1'b0;
          end
        end
        S_EMIT: if (!out_stall) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) cv_r[i] <= INIT_HASH[i];
            fill_r <= '0;
            bits_r <= '0;
            fin_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Schedule window: bytes shift in while gathering or padding; during rounds it rolls
  // by one word, appending the first word in rounds 0-15 and an expanded word after.
  always_ff @(posedge clk) begin
    if ((state_r == S_GATHER && take && q_data.has_byte) || state_r == S_PAD ||
        state_r == S_LEN) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_shift[i];
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(oidx_r)) else $error("emit moved");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_GATHER |-> !q_take) else $error("take while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == 6'd63 |=> state_r != S_ROUND) else $error("round overrun");

endmodule

### sim/tb_sha256_stream_hasher.sv
// Testbench for sha256_stream_hasher: byte beats in, digest words out, checked against
// an in-bench SHA-256 predictor. Depends on sha_pkg and the RTL of the hasher.
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
  import sha_pkg::*;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sha_out_t out_data;

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          fill_count;
  logic [63:0] bit_length;
  sha_out_t    digest_queue [$];
  int          fault_count;
  bit          quiet_mode;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("sha256_stream_hasher regression: fail");
    $finish;
  end

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 64; j++)
      w[j] = w[j-16] + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3))
           + w[j-7] + (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10));
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
  endfunction

  function automatic void hasher_clear();
    for (int j = 0; j < 8; j++) hash_state[j] = IV[j];
    fill_count = 0;
    bit_length = '0;
  endfunction

  // Absorbs one beat and queues the eight digest words when it closes the message.
  function automatic void absorb_beat(sha_in_t b);
    sha_out_t o;
    if (b.has_byte) begin
      msg_block[fill_count] = b.data_byte;
      fill_count++;
      bit_length += 64'd8;
      if (fill_count == 64) begin
        compress_block();
        fill_count = 0;
      end
    end
    if (!b.last) return;
    msg_block[fill_count] = PAD_BYTE;
    for (int i = fill_count + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (fill_count >= 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) msg_block[63-i] = bit_length[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = hash_state[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      digest_queue.push_back(o);
    end
    hasher_clear();
  endfunction

  // Valid stays high after the beat is taken; only an idle gap before the next beat lowers it.
  task automatic send_beat(logic [7:0] d, logic h, logic l);
    sha_in_t b;
    b.data_byte = d;
    b.has_byte = h;
    b.last = l;
    if (!quiet_mode) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_beat(b);
  endtask

  task automatic send_message(int len, bit empty_close);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, (!empty_close && i == len - 1));
    if (empty_close || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'haa, 1'b1, 1'b1);
  endtask

  task automatic test_empty_message();
    send_beat(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_known_abc();
    send_beat("a", 1'b1, 1'b0);
    send_beat("b", 1'b1, 1'b0);
    send_beat("c", 1'b1, 1'b1);
  endtask

  task automatic test_idle_beats();
    send_beat(8'h12, 1'b0, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'h56, 1'b0, 1'b0);
    send_beat(8'h78, 1'b0, 1'b1);
  endtask

  // A message ending at 56 bytes needs a second padding block; one whose last byte
  // fills the block needs a whole block of padding. The full block runs with no idling.
  task automatic test_block_boundaries();
    send_message(56, 1'b0);
    quiet_mode = 1'b1;
    send_message(64, 1'b0);
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_messages();
    int len;
    for (int m = 0; m < 3; m++) begin
      len = $urandom_range(0, 4);
      if ($urandom_range(5) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %b", $time,
                   out_data.digest_word, out_data.word_index, out_data.last_word);
          fault_count++;
        end else begin
          sha_out_t e;
          e = digest_queue.pop_front();
          if (e.digest_word !== out_data.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     e.digest_word, out_data.digest_word);
            fault_count++;
          end
          if (e.word_index !== out_data.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     e.word_index, out_data.word_index);
            fault_count++;
          end
          if (e.last_word !== out_data.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     e.last_word, out_data.last_word);
            fault_count++;
          end
        end
      end
      out_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 33);
    end
  end

  initial begin
    fault_count = 0;
    quiet_mode = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hasher_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_empty_message();
    test_known_abc();
    test_idle_beats();
    test_block_boundaries();
    test_random_messages();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fault_count == 0) begin
      $display("sha256_stream_hasher regression: pass");
    end else begin
      $display("sha256_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule
